/* rtl/sdka_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdka_pkg: shared types and constants
// Widths, outcome codes, limit indexes and the quotient unit bundles.
// ----------------------------------------------------------------------------
package sdka_pkg;

  localparam int DirW   = 32;
  localparam int LimitW = 40;
  localparam int LenW   = 63;
  localparam int NumCfg = 2;

  localparam logic [LenW-1:0] SqCap = 63'h4000000000000000;

  typedef enum logic [1:0] {
    OUT_AVG      = 2'd0,
    OUT_HALVED   = 2'd1,
    OUT_SINGULAR = 2'd2,
    OUT_SINGLE   = 2'd3
  } outcome_t;

  localparam logic CFG_PARALLEL = 1'b0;
  localparam logic CFG_SINGULAR = 1'b1;

  // Quotient unit start and status bundle
  typedef struct packed {
    logic        start;
    logic        neg;
    logic [63:0] mag;
    logic [62:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [34:0] quot;
  } div_rsp_t;

endpackage

/* rtl/sdka_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdka_div: scaled quotient unit
// Restoring division of a 64-bit magnitude by a 63-bit divisor, one bit per
// cycle, giving mag * 2^28 / den truncated, capped at 2^33.
// ----------------------------------------------------------------------------
module sdka_div (
  input  logic                clk,
  input  logic                rst,
  input  sdka_pkg::div_req_t  req,
  output sdka_pkg::div_rsp_t  rsp
);
  import sdka_pkg::*;

  localparam int Steps = 64 + 28;

  logic [63:0] rem;
  logic [91:0] dvd;
  logic [91:0] q;
  logic [62:0] den;
  logic        neg;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [64:0] trial;
  logic [63:0] shifted_rem;

  assign shifted_rem = {rem[62:0], dvd[91]};
  assign trial       = {1'b0, shifted_rem} - {2'b00, den};

  // Advance one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 7'd0;
        rem  <= '0;
        dvd  <= {req.mag, 28'd0};
        q    <= '0;
        den  <= req.den;
        neg  <= req.neg;
      end else if (busy) begin
        dvd <= {dvd[90:0], 1'b0};
        if (!trial[64] || rem[63]) begin
          rem <= trial[63:0];
          q   <= {q[90:0], 1'b1};
        end else begin
          rem <= shifted_rem;
          q   <= {q[90:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'(Steps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  logic [33:0] mag_q;
  assign mag_q = (q[91:33] != '0) ? 34'h200000000 : q[33:0];
  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = neg ? -{1'b0, mag_q} : {1'b0, mag_q};

endmodule

/* rtl/sdka_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdka_mul: shared multiplier
// One registered 32x32 signed multiply with the Q.28 floor shift.
// ----------------------------------------------------------------------------
module sdka_mul (
  input  logic               clk,
  input  logic signed [31:0] op_a,
  input  logic signed [31:0] op_b,
  output logic signed [35:0] prod28
);
  logic signed [63:0] prod;

  // Register the full product
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

  assign prod28 = prod[63:28];

endmodule

/* rtl/shell_director_kink_average.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shell_director_kink_average: shared director at a kink node
// Latches the first director, combines each later one with it through one
// shared multiplier and a bit-serial quotient unit; only the last is output.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                     | tuser / tlast
//  s_axis  | in  | dir_x, dir_y, dir_z (96 bits)          | tlast=last_director
//  m_axis  | out | shared_x, shared_y, shared_z (96 bits) | tuser=outcome
//  cfg     | in  | wr_en, wr_index, wr_data (40 bits)     | -
//
//  A first director that is not last is only latched; a single director
//  goes straight to the output step. A later director runs the cross and
//  dot multiplies and a compare, so a parallel or singular one leaves
//  through the output step. An averaging one, last or not, adds the w-term
//  multiplies and three quotient passes (one bit per cycle).
//  Reset is synchronous and clears reference, error and limits.
//  The result sits in its own register; the next node is taken while it
//  waits; the sequencer holds at the output step while it is full and stalled.
// ----------------------------------------------------------------------------
module shell_director_kink_average (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // dir_x, dir_y, dir_z
  input  logic         s_axis_tlast,   // last_director
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata,   // shared_x, shared_y, shared_z
  output logic [1:0]   m_axis_tuser,   // outcome
  input  logic         wr_en,
  input  logic         wr_index,
  input  logic [39:0]  wr_data
);
  import sdka_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_EVAL = 6'b000100,
    S_DIV  = 6'b001000,
    S_WAIT = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state;
  logic [LimitW-1:0] parallel_limit, singular_limit;
  logic signed [31:0] ax, ay, az, bx, by, bz;
  logic have_reference, error_seen, last;
  logic [4:0] step;
  logic [1:0] lane;
  logic signed [35:0] pr [0:14];
  logic signed [31:0] op_a, op_b;
  logic signed [35:0] prod28;
  logic signed [31:0] p_dot, s_dot, num;
  logic signed [31:0] w [0:2];
  logic [LenW-1:0] len;
  logic signed [31:0] rx, ry, rz;
  logic [1:0] outcome;
  logic out_load;
  div_req_t dreq;
  div_rsp_t drsp;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      parallel_limit <= '0;
      singular_limit <= '0;
    end else if (wr_en) begin
      if (wr_index == CFG_PARALLEL) parallel_limit <= wr_data;
      else                          singular_limit <= wr_data;
    end
  end

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    if (v > 38'sd2147483647)       return 32'sh7FFFFFFF;
    else if (v < -38'sd2147483648) return 32'sh80000000;
    else                           return v[31:0];
  endfunction

  function automatic logic [LenW-1:0] sq_sat(input logic signed [36:0] c);
    logic [36:0] m;
    m = c[36] ? -c : c;
    if (m[36:31] != '0) return SqCap;
    return LenW'(m[30:0] * m[30:0]);
  endfunction

  // Multiplier operand schedule: cross terms, dots, w terms
  always_comb begin
    op_a = ax; op_b = bx;
    case (step)
      5'd0:  begin op_a = ay; op_b = bz; end
      5'd1:  begin op_a = az; op_b = by; end
      5'd2:  begin op_a = az; op_b = bx; end
      5'd3:  begin op_a = ax; op_b = bz; end
      5'd4:  begin op_a = ax; op_b = by; end
      5'd5:  begin op_a = ay; op_b = bx; end
      5'd6:  begin op_a = ax; op_b = bx; end
      5'd7:  begin op_a = ay; op_b = by; end
      5'd8:  begin op_a = az; op_b = bz; end
      5'd9:  begin op_a = ax; op_b = ax; end
      5'd10: begin op_a = ay; op_b = ay; end
      5'd11: begin op_a = az; op_b = az; end
      5'd12: begin op_a = bx; op_b = bx; end
      5'd13: begin op_a = by; op_b = by; end
      5'd14: begin op_a = bz; op_b = bz; end
      5'd15: begin op_a = p_dot; op_b = ax; end
      5'd16: begin op_a = s_dot; op_b = bx; end
      5'd17: begin op_a = p_dot; op_b = ay; end
      5'd18: begin op_a = s_dot; op_b = by; end
      5'd19: begin op_a = p_dot; op_b = az; end
      5'd20: begin op_a = s_dot; op_b = bz; end
      default: begin op_a = ax; op_b = bx; end
    endcase
  end

  sdka_mul u_mul (.clk(clk), .op_a(op_a), .op_b(op_b), .prod28(prod28));
  sdka_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic signed [37:0] dsum_ab, dsum_aa, dsum_bb;
  assign dsum_ab = 38'(pr[6]) + 38'(pr[7]) + 38'(pr[8]);
  assign dsum_aa = 38'(pr[9]) + 38'(pr[10]) + 38'(pr[11]);
  assign dsum_bb = 38'(pr[12]) + 38'(pr[13]) + 38'(pr[14]);

  logic [LenW+1:0] lsum;
  assign lsum = 65'(sq_sat(37'(pr[0]) - 37'(pr[1]))) + 65'(sq_sat(37'(pr[2]) - 37'(pr[3])))
              + 65'(sq_sat(37'(pr[4]) - 37'(pr[5])));

  logic signed [63:0] nw;
  assign nw = num * w[lane];

  logic signed [31:0] lane_a;
  assign lane_a = (lane == 2'd0) ? ax : (lane == 2'd1) ? ay : az;

  assign s_axis_tready = (state == S_IDLE);
  assign out_load = (state == S_OUT) && last && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    dreq.start = 1'b0;
    dreq.neg   = nw[63];
    dreq.mag   = nw[63] ? 64'(-nw) : 64'(nw);
    dreq.den   = len;
    if (state == S_DIV) dreq.start = 1'b1;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      have_reference <= 1'b0;
      error_seen     <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            last <= s_axis_tlast;
            bx <= s_axis_tdata[31:0];
            by <= s_axis_tdata[63:32];
            bz <= s_axis_tdata[95:64];
            if (!have_reference) begin
              ax <= s_axis_tdata[31:0];
              ay <= s_axis_tdata[63:32];
              az <= s_axis_tdata[95:64];
              have_reference <= !s_axis_tlast;
              if (s_axis_tlast) begin
                rx <= s_axis_tdata[31:0];
                ry <= s_axis_tdata[63:32];
                rz <= s_axis_tdata[95:64];
                outcome <= OUT_SINGLE;
                state <= S_OUT;
              end
            end else begin
              step  <= 5'd0;
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          // product of the previous step lands now
          if (step != 5'd0) begin
            if (step <= 5'd15) pr[4'(step - 5'd1)] <= prod28;
            else begin
              if (step[0]) w[2'((step - 5'd17) >> 1)] <= sat32(38'(pr[0]) - 38'(prod28));
              else pr[0] <= prod28;
            end
          end
          if (step == 5'd15) begin
            len <= (lsum > 65'(SqCap)) ? SqCap : lsum[LenW-1:0];
            p_dot <= sat32(dsum_ab);
            s_dot <= sat32(dsum_aa);
            step  <= step;
            state <= S_EVAL;
          end else if (step == 5'd21) begin
            lane  <= 2'd0;
            state <= S_DIV;
          end else begin
            step <= step + 5'd1;
          end
        end
        S_EVAL: begin
          num <= sat32(38'(p_dot) - 38'(sat32(dsum_bb)));
          if (len <= LenW'(parallel_limit)) begin
            rx <= 32'((33'(ax) + 33'(bx)) >>> 1);
            ry <= 32'((33'(ay) + 33'(by)) >>> 1);
            rz <= 32'((33'(az) + 33'(bz)) >>> 1);
            outcome <= OUT_HALVED;
            state <= S_OUT;
          end else if (len <= LenW'(singular_limit)) begin
            error_seen <= 1'b1;
            outcome <= OUT_SINGULAR;
            state <= S_OUT;
          end else begin
            outcome <= OUT_AVG;
            step  <= 5'd16;
            state <= S_MUL;
          end
        end
        S_DIV: state <= S_WAIT;
        S_WAIT: begin
          if (drsp.done) begin
            case (lane)
              2'd0: rx <= sat32(38'(lane_a) + 38'($signed(drsp.quot)));
              2'd1: ry <= sat32(38'(lane_a) + 38'($signed(drsp.quot)));
              default: rz <= sat32(38'(lane_a) + 38'($signed(drsp.quot)));
            endcase
            if (lane == 2'd2) state <= S_OUT;
            else begin
              lane  <= lane + 2'd1;
              state <= S_DIV;
            end
          end
        end
        S_OUT: begin
          // hold the finished node while an earlier result still waits
          if (!last) state <= S_IDLE;
          else if (out_load) begin
            have_reference <= 1'b0;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result register: load a finished node, drop it once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
      if (error_seen) begin
        m_axis_tuser <= OUT_SINGULAR;
        m_axis_tdata <= '0;
      end else begin
        m_axis_tuser <= outcome;
        m_axis_tdata <= {rz, ry, rx};
      end
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

endmodule

/* rtl/sdka_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdka_checker: port-level checks
// Watches handshakes and result codes on the top level.
// ----------------------------------------------------------------------------
module sdka_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [95:0]  m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);
  import sdka_pkg::*;

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result dropped while stalled");

  // Keep an offered input until it is taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid)
    else $error("input withdrawn before transfer");

  // Singular result carries zero vectors
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == OUT_SINGULAR |-> m_axis_tdata == '0)
    else $error("singular result not zero");

  // Reset leaves no result pending
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result after reset");
endmodule

bind shell_director_kink_average sdka_checker u_sdka_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
  .m_axis_tuser(m_axis_tuser)
);

/* sim/shell_director_kink_average_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shell_director_kink_average_tb: self-checking bench for the kink averager
// Drives director streams with random gaps and output stalls, predicts each
// shared director in fixed point and checks every result transfer in order.
// ----------------------------------------------------------------------------
module shell_director_kink_average_tb;
  import sdka_pkg::*;

  typedef struct packed {
    logic [31:0] sx;
    logic [31:0] sy;
    logic [31:0] sz;
    logic [1:0]  oc;
  } shared_t;

  // Fixed-point predictor and the queue of expected shared directors
  class kink_scoreboard;
    longint par_lim, sing_lim;
    longint ref_d [3];
    bit have_ref, err_seen;
    shared_t pending[$];
    int errors;

    function new();
      par_lim = 0; sing_lim = 0; have_ref = 0; err_seen = 0; errors = 0;
      ref_d[0] = 0; ref_d[1] = 0; ref_d[2] = 0;
    endfunction

    function longint sat32(longint v);
      if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
      if (v < -64'sh80000000) return -64'sh80000000;
      return v;
    endfunction

    function longint mul28(longint x, longint y);
      return (x * y) >>> 28;
    endfunction

    function longint unsigned sq_sat(longint c);
      longint unsigned m;
      m = (c < 0) ? -c : c;
      if (m >= 64'h80000000) return 64'h4000000000000000;
      return m * m;
    endfunction

    function longint dot28(longint a [3], longint b [3]);
      return sat32(mul28(a[0], b[0]) + mul28(a[1], b[1]) + mul28(a[2], b[2]));
    endfunction

    function longint quot(longint num, longint w, longint unsigned den);
      longint p;
      longint unsigned m, q, r;
      bit neg;
      p = num * w;
      neg = p < 0;
      m = neg ? -p : p;
      q = m / den;
      r = m % den;
      if (q >= 32) q = 64'h200000000;
      else begin
        for (int i = 0; i < 28; i++) begin
          r = r << 1; q = q << 1;
          if (r >= den) begin
            r = r - den; q = q | 1;
          end
        end
      end
      return neg ? -longint'(q) : longint'(q);
    endfunction

    function void note_director(logic [95:0] d, logic last);
      longint b [3], a [3], r [3], c [3];
      longint unsigned len;
      longint p, s, t, num, w;
      logic [1:0] oc;
      shared_t e;
      for (int i = 0; i < 3; i++) begin
        b[i] = longint'($signed(d[32*i +: 32]));
        r[i] = 0;
      end
      if (!have_ref) begin
        ref_d = b;
        have_ref = !last;
        if (!last) return;
        oc = OUT_SINGLE;
        r = b;
      end else begin
        a = ref_d;
        c[0] = mul28(a[1], b[2]) - mul28(a[2], b[1]);
        c[1] = mul28(a[2], b[0]) - mul28(a[0], b[2]);
        c[2] = mul28(a[0], b[1]) - mul28(a[1], b[0]);
        len = sq_sat(c[0]) + sq_sat(c[1]) + sq_sat(c[2]);
        if (len > 64'h4000000000000000) len = 64'h4000000000000000;
        if (len <= par_lim) begin
          oc = OUT_HALVED;
          for (int i = 0; i < 3; i++) r[i] = (a[i] + b[i]) >>> 1;
        end else if (len <= sing_lim) begin
          oc = OUT_SINGULAR;
          err_seen = 1;
        end else begin
          p = dot28(a, b); s = dot28(a, a); t = dot28(b, b);
          num = sat32(p - t);
          oc = OUT_AVG;
          for (int i = 0; i < 3; i++) begin
            w = sat32(mul28(p, a[i]) - mul28(s, b[i]));
            r[i] = sat32(a[i] + quot(num, w, len));
          end
        end
        if (!last) return;
        have_ref = 0;
      end
      if (err_seen) begin
        oc = OUT_SINGULAR; r[0] = 0; r[1] = 0; r[2] = 0;
      end
      e.sx = r[0][31:0]; e.sy = r[1][31:0]; e.sz = r[2][31:0]; e.oc = oc;
      pending.push_back(e);
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    task check_shared(logic [95:0] d, logic [1:0] u);
      shared_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %h / %0d", d, u));
        return;
      end
      e = pending.pop_front();
      if (d[31:0] !== e.sx) report($sformatf("x %h exp %h", d[31:0], e.sx));
      if (d[63:32] !== e.sy) report($sformatf("y %h exp %h", d[63:32], e.sy));
      if (d[95:64] !== e.sz) report($sformatf("z %h exp %h", d[95:64], e.sz));
      if (u !== e.oc) report($sformatf("outcome %0d exp %0d", u, e.oc));
    endtask
  endclass

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready, s_axis_tlast;
  logic [95:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [95:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic wr_en, wr_index;
  logic [39:0] wr_data;
  kink_scoreboard sb;
  bit calm;
  int idle_cycles;

  shell_director_kink_average dut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Sample result transfers and watch for a hung block
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_shared(m_axis_tdata, m_axis_tuser);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 20000) begin
        $display("shell_director_kink_average verification failed");
        $finish;
      end
    end
  end

  // Stall the result side in random bursts
  initial begin
    m_axis_tready = 0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready = 0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      m_axis_tready = 1;
    end
  end

  task automatic write_limit(logic idx, logic [39:0] val);
    @(negedge clk);
    wr_en = 1; wr_index = idx; wr_data = val;
    @(negedge clk);
    wr_en = 0;
    if (idx == CFG_PARALLEL) sb.par_lim = val; else sb.sing_lim = val;
  endtask

  task automatic send_director(logic [95:0] d, logic last);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    s_axis_tvalid = 1; s_axis_tdata = d; s_axis_tlast = last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_director(d, last);
    @(negedge clk);
    s_axis_tvalid = 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2: return 32'h10000000;
      3: return 32'hF0000000;
      default: return $urandom_range(0, 1) ? $urandom : 32'($signed($urandom) >>> 3);
    endcase
  endfunction

  function automatic logic [95:0] rand_dir();
    return {rand_comp(), rand_comp(), rand_comp()};
  endfunction

  // Random node: one to four directors, last one marked
  task automatic random_node();
    int n;
    logic [95:0] a;
    n = $urandom_range(1, 4);
    a = rand_dir();
    for (int k = 0; k < n; k++) begin
      if (k > 0 && $urandom_range(0, 3) == 0) a = a ^ 96'($urandom_range(0, 255));
      else if (k > 0) a = rand_dir();
      send_director(a, k == n - 1);
    end
  endtask

  initial begin
    logic [39:0] lims [4];
    sb = new();
    calm = 0; idle_cycles = 0;
    rst = 1; s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tlast = 0;
    wr_en = 0; wr_index = 0; wr_data = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: single director, parallel halving, averaging, extremes
    write_limit(CFG_PARALLEL, 40'd1000);
    write_limit(CFG_SINGULAR, 40'd0);
    send_director({32'h10000000, 32'h0, 32'h0}, 1);
    send_director({32'h80000000, 32'h80000000, 32'h80000000}, 1);
    send_director({32'h10000000, 32'h0, 32'h0}, 0);
    send_director({32'h10000000, 32'h0, 32'h0}, 1);
    send_director({32'h10000000, 32'h0, 32'h0}, 0);
    send_director({32'h0, 32'h10000000, 32'h0}, 1);
    send_director({32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF}, 0);
    send_director({32'h80000000, 32'h7FFFFFFF, 32'h0}, 0);
    send_director({32'h0, 32'h10000000, 32'h10000000}, 1);
    send_director({32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF}, 0);
    send_director({32'h0, 32'h0, 32'h1}, 1);
    drain();
    write_limit(CFG_PARALLEL, 40'hFFFFFFFFFF);
    send_director({32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF}, 0);
    send_director({32'h80000000, 32'h80000000, 32'h80000000}, 1);
    drain();
    // Singular kink then sticky error on later nodes
    write_limit(CFG_PARALLEL, 40'd0);
    write_limit(CFG_SINGULAR, 40'hFFFFFFFFFF);
    send_director({32'h0, 32'h0, 32'h10000000}, 0);
    send_director({32'h0, 32'h8000000, 32'h10000000}, 1);
    send_director({32'h0, 32'h0, 32'h10000000}, 1);
    drain();

    // Random phases; reset only once, so the error stays after a singular one
    lims[0] = 40'd0; lims[1] = 40'hFFFFFFFFFF; lims[2] = 40'h00FFFFFFFF;
    lims[3] = 40'h0000FFFFFF;
    for (int ph = 0; ph < 6; ph++) begin
      write_limit(CFG_PARALLEL,
                  ph == 0 ? 40'd0 : 40'({$urandom, $urandom} & lims[$urandom_range(0, 3)]));
      write_limit(CFG_SINGULAR, ph < 4 ? 40'd0 : 40'(lims[$urandom_range(0, 3)]));
      if (ph == 5) calm = 1;
      for (int i = 0; i < 90; i++) random_node();
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("shell_director_kink_average verification clean");
    else
      $display("shell_director_kink_average verification failed");
    $finish;
  end
endmodule

/* files.f */
rtl/sdka_pkg.sv
rtl/sdka_div.sv
rtl/sdka_mul.sv
rtl/shell_director_kink_average.sv
rtl/sdka_checker.sv
sim/shell_director_kink_average_tb.sv
